// File: design/swsf_pkg.sv
// ----------------------------------------------------------------------------
// swsf_pkg
// Shared types, codes and constants of the wheel speed factor pipeline.
// ----------------------------------------------------------------------------
package swsf_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_STEERING_MODEL = 2'd0;
    localparam logic [1:0] REG_STEERING_HOLE  = 2'd1;
    localparam logic [1:0] REG_AXIS_HOLE      = 2'd2;

    // steering geometry codes
    localparam logic [1:0] MODEL_COMBINED    = 2'd0;
    localparam logic [1:0] MODEL_ARTICULATED = 2'd1;
    localparam logic [1:0] MODEL_TURNTABLE   = 2'd2;

    localparam int ANGLE_W     = 15;
    localparam int DIST_W      = 12;   // signed half-millimetre distance
    localparam int HOLE_DIST_W = 11;   // unsigned half-millimetre mount distance
    localparam int RADIUS_W    = 17;
    localparam int FACTOR_W    = 16;

    localparam logic [HOLE_DIST_W-1:0] STEER_BASE_HMM = 11'd285;
    localparam logic [HOLE_DIST_W-1:0] AXIS_BASE_HMM  = 11'd605;
    localparam logic [HOLE_DIST_W-1:0] HOLE_STEP_HMM  = 11'd40;

    localparam logic [15:0] HALF_TRACK_MM = 16'd74;
    localparam logic [15:0] RADIUS_MAX    = 16'd65535;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_XY_W  = 34;
    localparam int CORDIC_Z_W   = 32;

    typedef logic signed [CORDIC_XY_W-1:0] cordic_xy_t;
    typedef logic signed [CORDIC_Z_W-1:0]  cordic_z_t;

    localparam cordic_xy_t CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam cordic_xy_t ONE_Q30         = 34'sd1073741824;

    // arctangent of 2^-i in Q16 degrees
    function automatic cordic_z_t cordic_atan(input int idx);
        cordic_z_t v;
        v = '0;
        case (idx)
            0:  v = 32'sd2949120;
            1:  v = 32'sd1740967;
            2:  v = 32'sd919879;
            3:  v = 32'sd466945;
            4:  v = 32'sd234379;
            5:  v = 32'sd117305;
            6:  v = 32'sd58666;
            7:  v = 32'sd29335;
            8:  v = 32'sd14668;
            9:  v = 32'sd7334;
            10: v = 32'sd3667;
            11: v = 32'sd1833;
            12: v = 32'sd917;
            13: v = 32'sd458;
            14: v = 32'sd229;
            15: v = 32'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [FACTOR_W-1:0] sat_factor(input logic [31:0] v);
        return (v > 32'h0000_FFFF) ? 16'hFFFF : v[FACTOR_W-1:0];
    endfunction

endpackage

// File: design/swsf_div.sv
// ----------------------------------------------------------------------------
// swsf_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Expects num >> QW below den; the quotient is then exact.
// ----------------------------------------------------------------------------
module swsf_div #(
    parameter int NW = 25,
    parameter int DW = 11,
    parameter int QW = 15,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    logic [QW:0]   vld_reg;
    logic [DW-1:0] rem_reg  [QW+1];
    logic [QW-1:0] pq_reg   [QW+1];
    logic [DW-1:0] den_reg  [QW+1];
    logic [SW-1:0] side_reg [QW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[QW-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= DW'(in_num >> QW);
            pq_reg[0]   <= in_num[QW-1:0];
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
        end
    end

    for (genvar g = 1; g <= QW; g++) begin : g_step
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          take;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] pq_next;

        // shift the next dividend bit in, subtract when it fits
        assign trial    = {rem_reg[g-1], pq_reg[g-1][QW-1]};
        assign diff     = trial - {1'b0, den_reg[g-1]};
        assign take     = trial >= {1'b0, den_reg[g-1]};
        assign rem_next = take ? diff[DW-1:0] : trial[DW-1:0];
        assign pq_next  = {pq_reg[g-1][QW-2:0], take};

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[g]  <= rem_next;
                pq_reg[g]   <= pq_next;
                den_reg[g]  <= den_reg[g-1];
                side_reg[g] <= side_reg[g-1];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign out_quo   = pq_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

// File: design/swsf_cordic.sv
// ----------------------------------------------------------------------------
// swsf_cordic
// Sixteen-stage rotation CORDIC in degrees: Q16 angle in, Q30 sine/cosine out.
// ----------------------------------------------------------------------------
module swsf_cordic #(
    parameter int SW = 14
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  swsf_pkg::cordic_z_t in_z,
    input  logic [SW-1:0]       in_side,
    output logic                out_valid,
    output swsf_pkg::cordic_xy_t out_cos,
    output swsf_pkg::cordic_xy_t out_sin,
    output logic [SW-1:0]       out_side
);
    import swsf_pkg::*;

    logic [CORDIC_STEPS-1:0] vld_reg;
    cordic_xy_t              x_reg    [CORDIC_STEPS];
    cordic_xy_t              y_reg    [CORDIC_STEPS];
    cordic_z_t               z_reg    [CORDIC_STEPS];
    logic [SW-1:0]           side_reg [CORDIC_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[CORDIC_STEPS-2:0], in_valid};
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
        cordic_xy_t    x_src;
        cordic_xy_t    y_src;
        cordic_z_t     z_src;
        logic [SW-1:0] side_src;
        cordic_xy_t    x_next;
        cordic_xy_t    y_next;
        cordic_z_t     z_next;

        if (g == 0) begin : g_first
            assign x_src    = CORDIC_GAIN_Q30;
            assign y_src    = '0;
            assign z_src    = in_z;
            assign side_src = in_side;
        end else begin : g_rest
            assign x_src    = x_reg[g-1];
            assign y_src    = y_reg[g-1];
            assign z_src    = z_reg[g-1];
            assign side_src = side_reg[g-1];
        end

        always_comb begin
            if (z_src >= 0) begin
                x_next = x_src - (y_src >>> g);
                y_next = y_src + (x_src >>> g);
                z_next = z_src - cordic_atan(g);
            end else begin
                x_next = x_src + (y_src >>> g);
                y_next = y_src - (x_src >>> g);
                z_next = z_src + cordic_atan(g);
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                x_reg[g]    <= x_next;
                y_reg[g]    <= y_next;
                z_reg[g]    <= z_next;
                side_reg[g] <= side_src;
            end
        end
    end

    assign out_valid = vld_reg[CORDIC_STEPS-1];
    assign out_cos   = x_reg[CORDIC_STEPS-1];
    assign out_sin   = y_reg[CORDIC_STEPS-1];
    assign out_side  = side_reg[CORDIC_STEPS-1];

endmodule

// File: design/steering_wheel_speed_factors_unit.sv
// ----------------------------------------------------------------------------
// steering_wheel_speed_factors_unit
// Turn radius and rear wheel speed factors from one steering angle.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one signed Q.ANGLE_FRAC_BITS steering angle per beat.
//   m_ channel: per angle one beat with right/left factors (unsigned
//   Q.FACTOR_FRAC_BITS), the signed middle turn radius in mm and a clip flag.
//   cfg_ channel: index 0 steering model, 1 steering hole, 2 axis hole;
//   always ready, write only while no beat is in flight.
// Pipeline: stages a and b, the angle divider, stage c, the 16-stage
//   CORDIC, stages d and e, the radius divider, stage f, the factor
//   dividers and output stage g, one bit or step per stage.
// Throughput: one beat per cycle while the pipeline is not stalled.
// Reset: clears all stage valid bits and loads the geometry defaults
//   (turntable, steering hole 0, axis hole 1).
// Stall: while m_valid is high and m_ready low the whole pipeline holds
//   and s_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module steering_wheel_speed_factors_unit #(
    parameter int ANGLE_FRAC_BITS  = 8,
    parameter int FACTOR_FRAC_BITS = 14
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [1:0]                             cfg_index,
    input  logic [3:0]                             cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [swsf_pkg::ANGLE_W-1:0]    s_servo_angle,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [swsf_pkg::FACTOR_W-1:0]          m_right_factor,
    output logic [swsf_pkg::FACTOR_W-1:0]          m_left_factor,
    output logic signed [swsf_pkg::RADIUS_W-1:0]   m_turn_radius,
    output logic                                   m_radius_clipped
);
    import swsf_pkg::*;

    localparam int ANG_MAG_W = ANGLE_W;
    localparam int PROD_W    = 25;
    localparam int NUM_W     = 42;
    localparam int DEN_W     = 33;
    localparam int FNUM_W    = 17 + FACTOR_FRAC_BITS;
    localparam int FQ_W      = FACTOR_FRAC_BITS + 2;
    localparam int Z_SHIFT   = 16 - ANGLE_FRAC_BITS;
    localparam logic [16:0] SMALL_LIM = 17'(4 << ANGLE_FRAC_BITS);
    localparam logic [FACTOR_W-1:0] ONE_FACTOR =
        sat_factor(32'(64'd1 << FACTOR_FRAC_BITS));

    logic adv;
    assign adv       = !m_valid || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    // ---------------- configuration ----------------
    logic [1:0] model_reg;
    logic [3:0] steer_hole_reg;
    logic [3:0] axis_hole_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            model_reg      <= MODEL_TURNTABLE;
            steer_hole_reg <= 4'd0;
            axis_hole_reg  <= 4'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_STEERING_MODEL: model_reg      <= cfg_data[1:0];
                REG_STEERING_HOLE:  steer_hole_reg <= cfg_data;
                REG_AXIS_HOLE:      axis_hole_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage a: geometry ----------------
    logic [HOLE_DIST_W-1:0]   sp2;
    logic [HOLE_DIST_W-1:0]   ax2;
    logic signed [DIST_W-1:0] d2_next;
    logic                     tan_next;
    logic [ANG_MAG_W-1:0]     ang_abs;
    logic                     active_next;

    assign sp2 = STEER_BASE_HMM + HOLE_STEP_HMM * HOLE_DIST_W'(steer_hole_reg);
    assign ax2 = AXIS_BASE_HMM + HOLE_STEP_HMM * HOLE_DIST_W'(axis_hole_reg);

    always_comb begin
        d2_next  = '0;
        tan_next = 1'b0;
        case (model_reg)
            MODEL_COMBINED:    d2_next = $signed({1'b0, sp2});
            MODEL_ARTICULATED: begin
                d2_next  = $signed({1'b0, ax2}) - $signed({1'b0, sp2});
                tan_next = 1'b1;
            end
            MODEL_TURNTABLE:   d2_next = $signed({1'b0, ax2});
            default:           d2_next = '0;
        endcase
    end

    assign ang_abs     = s_servo_angle[ANGLE_W-1] ? ANG_MAG_W'(-s_servo_angle)
                                                  : ANG_MAG_W'(s_servo_angle);
    assign active_next = ({2'b00, ang_abs} >= SMALL_LIM) && (d2_next != '0);

    logic                      a_vld_reg;
    logic signed [ANGLE_W-1:0] a_ang_reg;
    logic signed [DIST_W-1:0]  a_d2_reg;
    logic [HOLE_DIST_W-1:0]    a_ax2_reg;
    logic                      a_tan_reg;
    logic                      a_act_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (adv) begin
            a_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_ang_reg <= s_servo_angle;
            a_d2_reg  <= d2_next;
            a_ax2_reg <= ax2;
            a_tan_reg <= tan_next;
            a_act_reg <= active_next;
        end
    end

    // ---------------- stage b: angle times distance ----------------
    logic signed [ANGLE_W+DIST_W-1:0] b_prod;
    logic                             b_vld_reg;
    logic [PROD_W-1:0]                b_mag_reg;
    logic                             b_neg_reg;
    logic signed [ANGLE_W-1:0]        b_ang_reg;
    logic signed [DIST_W-1:0]         b_d2_reg;
    logic [HOLE_DIST_W-1:0]           b_ax2_reg;
    logic                             b_tan_reg;
    logic                             b_act_reg;

    assign b_prod = a_ang_reg * a_d2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (adv) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_mag_reg <= b_prod[ANGLE_W+DIST_W-1] ? PROD_W'(-b_prod) : PROD_W'(b_prod);
            b_neg_reg <= b_prod[ANGLE_W+DIST_W-1];
            b_ang_reg <= a_ang_reg;
            b_d2_reg  <= a_d2_reg;
            b_ax2_reg <= a_ax2_reg;
            b_tan_reg <= a_tan_reg;
            b_act_reg <= a_act_reg;
        end
    end

    // ---------------- articulated angle scale ----------------
    localparam int ESIDE_W = ANGLE_W + DIST_W + 3;
    logic                      e_vld;
    logic [ANGLE_W-1:0]        e_quo;
    logic [ESIDE_W-1:0]        e_side;
    logic signed [ANGLE_W-1:0] e_ang;
    logic signed [DIST_W-1:0]  e_d2;
    logic                      e_tan;
    logic                      e_act;
    logic                      e_neg;

    swsf_div #(
        .NW(PROD_W), .DW(HOLE_DIST_W), .QW(ANGLE_W), .SW(ESIDE_W)
    ) u_eff_div (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(b_vld_reg), .in_num(b_mag_reg), .in_den(b_ax2_reg),
        .in_side({b_ang_reg, b_d2_reg, b_tan_reg, b_act_reg, b_neg_reg}),
        .out_valid(e_vld), .out_quo(e_quo), .out_side(e_side)
    );

    assign {e_ang, e_d2, e_tan, e_act, e_neg} = e_side;

    // ---------------- stage c: cordic angle ----------------
    logic signed [ANGLE_W-1:0] c_eff;
    cordic_z_t                 c_z_next;
    logic                      c_vld_reg;
    cordic_z_t                 c_z_reg;
    logic [DIST_W+1:0]         c_side_reg;

    assign c_eff    = e_tan ? (e_neg ? -$signed(e_quo) : $signed(e_quo)) : e_ang;
    assign c_z_next = {{(CORDIC_Z_W-ANGLE_W){c_eff[ANGLE_W-1]}}, c_eff} <<< Z_SHIFT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (adv) begin
            c_vld_reg <= e_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_z_reg    <= c_z_next;
            c_side_reg <= {e_d2, e_tan, e_act};
        end
    end

    logic                     k_vld;
    cordic_xy_t               k_cos;
    cordic_xy_t               k_sin;
    logic [DIST_W+1:0]        k_side;
    logic signed [DIST_W-1:0] k_d2;
    logic                     k_tan;
    logic                     k_act;

    swsf_cordic #(.SW(DIST_W + 2)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(c_vld_reg), .in_z(c_z_reg), .in_side(c_side_reg),
        .out_valid(k_vld), .out_cos(k_cos), .out_sin(k_sin), .out_side(k_side)
    );

    assign {k_d2, k_tan, k_act} = k_side;

    // ---------------- stage d: radius numerator and denominator ----------------
    cordic_xy_t                          d_mul_b;
    logic signed [DIST_W+CORDIC_XY_W-1:0] d_num;
    cordic_xy_t                          d_sin_abs;
    logic                                d_vld_reg;
    logic [NUM_W-1:0]                    d_num_reg;
    logic [DEN_W-1:0]                    d_den_reg;
    logic                                d_live_reg;
    logic                                d_rneg_reg;

    assign d_mul_b   = k_tan ? k_cos : ONE_Q30;
    assign d_num     = k_d2 * d_mul_b;
    assign d_sin_abs = k_sin[CORDIC_XY_W-1] ? -k_sin : k_sin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (adv) begin
            d_vld_reg <= k_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_num_reg  <= d_num[DIST_W+CORDIC_XY_W-1] ? NUM_W'(-d_num) : NUM_W'(d_num);
            d_den_reg  <= {d_sin_abs[DEN_W-2:0], 1'b0};
            d_live_reg <= k_act && (k_sin != '0);
            d_rneg_reg <= d_num[DIST_W+CORDIC_XY_W-1] ^ k_sin[CORDIC_XY_W-1];
        end
    end

    // ---------------- stage e: saturation check ----------------
    logic             x_vld_reg;
    logic [NUM_W-1:0] x_num_reg;
    logic [DEN_W-1:0] x_den_reg;
    logic [2:0]       x_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_vld_reg <= 1'b0;
        end else if (adv) begin
            x_vld_reg <= d_vld_reg;
        end
    end

    // quotient of 65536 or more saturates
    always_ff @(posedge aclk) begin
        if (adv) begin
            x_num_reg  <= d_num_reg;
            x_den_reg  <= d_den_reg;
            x_side_reg <= {d_live_reg, d_rneg_reg,
                           DEN_W'(d_num_reg >> 16) >= d_den_reg};
        end
    end

    logic        r_vld;
    logic [15:0] r_quo;
    logic [2:0]  r_side;
    logic        r_live;
    logic        r_neg;
    logic        r_clip;

    swsf_div #(
        .NW(NUM_W), .DW(DEN_W), .QW(16), .SW(3)
    ) u_radius_div (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(x_vld_reg), .in_num(x_num_reg), .in_den(x_den_reg),
        .in_side(x_side_reg),
        .out_valid(r_vld), .out_quo(r_quo), .out_side(r_side)
    );

    assign {r_live, r_neg, r_clip} = r_side;

    // ---------------- stage f: radius and factor numerators ----------------
    logic [15:0]                f_mag;
    logic                       f_vld_reg;
    logic signed [RADIUS_W-1:0] f_r_reg;
    logic                       f_clip_reg;
    logic                       f_big_reg;
    logic [15:0]                f_m_reg;
    logic [FNUM_W-1:0]          f_near_reg;
    logic [FNUM_W-1:0]          f_far_reg;

    assign f_mag = !r_live ? 16'd0 : (r_clip ? RADIUS_MAX : r_quo);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= 1'b0;
        end else if (adv) begin
            f_vld_reg <= r_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_r_reg    <= r_neg ? -$signed({1'b0, f_mag}) : $signed({1'b0, f_mag});
            f_clip_reg <= r_live && r_clip;
            f_big_reg  <= f_mag >= HALF_TRACK_MM;
            f_m_reg    <= f_mag;
            f_near_reg <= FNUM_W'(f_mag - HALF_TRACK_MM) << FACTOR_FRAC_BITS;
            f_far_reg  <= (FNUM_W'(f_mag) + FNUM_W'(HALF_TRACK_MM)) << FACTOR_FRAC_BITS;
        end
    end

    logic                       n_vld;
    logic [FQ_W-1:0]            n_quo;
    logic [RADIUS_W:0]          n_side;
    logic signed [RADIUS_W-1:0] n_r;
    logic                       n_clip;
    logic                       w_vld;
    logic [FQ_W-1:0]            w_quo;
    logic                       w_big;

    swsf_div #(
        .NW(FNUM_W), .DW(16), .QW(FQ_W), .SW(RADIUS_W + 1)
    ) u_near_div (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(f_vld_reg), .in_num(f_near_reg), .in_den(f_m_reg),
        .in_side({f_r_reg, f_clip_reg}),
        .out_valid(n_vld), .out_quo(n_quo), .out_side(n_side)
    );

    swsf_div #(
        .NW(FNUM_W), .DW(16), .QW(FQ_W), .SW(1)
    ) u_far_div (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(f_vld_reg), .in_num(f_far_reg), .in_den(f_m_reg),
        .in_side(f_big_reg),
        .out_valid(w_vld), .out_quo(w_quo), .out_side(w_big)
    );

    assign {n_r, n_clip} = n_side;

    // ---------------- stage g: output register ----------------
    logic [FACTOR_W-1:0]        near_sat;
    logic [FACTOR_W-1:0]        far_sat;
    logic                       m_valid_reg;
    logic [FACTOR_W-1:0]        m_right_reg;
    logic [FACTOR_W-1:0]        m_left_reg;
    logic signed [RADIUS_W-1:0] m_radius_reg;
    logic                       m_clip_reg;

    assign near_sat = sat_factor(32'(n_quo));
    assign far_sat  = sat_factor(32'(w_quo));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= n_vld && w_vld;
        end
    end

    // inner wheel gets the near factor
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (!w_big) begin
                m_right_reg <= ONE_FACTOR;
                m_left_reg  <= ONE_FACTOR;
            end else if (!n_r[RADIUS_W-1]) begin
                m_right_reg <= near_sat;
                m_left_reg  <= far_sat;
            end else begin
                m_right_reg <= far_sat;
                m_left_reg  <= near_sat;
            end
            m_radius_reg <= n_r;
            m_clip_reg   <= n_clip;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_right_factor   = m_right_reg;
    assign m_left_factor    = m_left_reg;
    assign m_turn_radius    = m_radius_reg;
    assign m_radius_clipped = m_clip_reg;

`ifndef SYNTHESIS
    a_clip_at_limit : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_radius_clipped |->
            (m_turn_radius == 17'sd65535) || (m_turn_radius == -17'sd65535))
        else $error("clipped radius not at limit");

    a_straight_unity : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_turn_radius == '0) |->
            (m_right_factor == ONE_FACTOR) && (m_left_factor == ONE_FACTOR))
        else $error("straight ahead factors not unity");

    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

    a_stall_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready ##1 (m_valid && $stable({m_right_factor,
            m_left_factor, m_turn_radius, m_radius_clipped})))
        else $error("pipeline moved under stall");
`endif

endmodule

// File: tb/steering_wheel_speed_factors_unit_tb.sv
// ----------------------------------------------------------------------------
// steering_wheel_speed_factors_unit_tb
// Self-checking bench for the wheel speed factor pipeline. Steering angles
// are fed through the s_ channel across several geometry settings; each
// result beat is compared against a bit-exact CORDIC and divider predictor.
// ----------------------------------------------------------------------------
module steering_wheel_speed_factors_unit_tb;
    import swsf_pkg::*;

    localparam int AFB = 8;
    localparam int FFB = 14;
    localparam int LATENCY = 59 + FFB;

    typedef struct packed {
        logic [FACTOR_W-1:0] right_f;
        logic [FACTOR_W-1:0] left_f;
        logic [RADIUS_W-1:0] radius;
        logic                clipped;
    } wheel_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = REG_STEERING_MODEL;
    logic [3:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [ANGLE_W-1:0] s_servo_angle = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [FACTOR_W-1:0] m_right_factor, m_left_factor;
    logic signed [RADIUS_W-1:0] m_turn_radius;
    logic m_radius_clipped;

    steering_wheel_speed_factors_unit #(.ANGLE_FRAC_BITS(AFB), .FACTOR_FRAC_BITS(FFB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_servo_angle(s_servo_angle),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_right_factor(m_right_factor), .m_left_factor(m_left_factor),
        .m_turn_radius(m_turn_radius), .m_radius_clipped(m_radius_clipped)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // predictor copy of the geometry registers
    logic [1:0] geo_model = MODEL_TURNTABLE;
    logic [3:0] geo_steer_hole = 4'd0;
    logic [3:0] geo_axis_hole = 4'd1;

    logic signed [ANGLE_W-1:0] angle_q[$];
    wheel_res_t expected_q[$];
    int errors = 0;
    int mismatches = 0;
    bit sender_hold = 1'b0;
    bit stall_burst = 1'b0;
    bit quiet_phase = 1'b0;

    function automatic longint floor_shr(longint v, int s);
        if (v < 0) return ~((~v) >>> s);
        return v >>> s;
    endfunction

    function automatic longint atan_q16(int i);
        longint tbl[16] = '{2949120, 1740967, 919879, 466945, 234379, 117305, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        return tbl[i];
    endfunction

    function automatic longint clamp_factor(longint f);
        if (f < 0) return 0;
        if (f > 64'hFFFF) return 64'hFFFF;
        return f;
    endfunction

    function automatic wheel_res_t predict_wheel_factors(logic signed [ANGLE_W-1:0] ang_in);
        longint angle, sp2, ax2, lim, d2, eff, r, x, y, z, xs, ys, num, m, nearf, farf;
        longint one, rf, lf;
        bit use_tan, clip;
        wheel_res_t res;
        angle = ang_in;
        sp2 = 285 + 40 * longint'(geo_steer_hole);
        ax2 = 605 + 40 * longint'(geo_axis_hole);
        lim = 4 << AFB;
        eff = angle;
        r = 0;
        use_tan = 0;
        clip = 0;
        one = 1 << FFB;
        rf = one;
        lf = one;
        case (geo_model)
            MODEL_COMBINED:    d2 = sp2;
            MODEL_ARTICULATED: begin
                d2 = ax2 - sp2;
                eff = angle * d2 / ax2;
                use_tan = 1;
            end
            MODEL_TURNTABLE:   d2 = ax2;
            default:           d2 = 0;
        endcase
        if (!(angle < lim && angle > -lim) && d2 != 0) begin
            x = 652032874;
            y = 0;
            z = eff * (1 << (16 - AFB));
            for (int i = 0; i < 16; i++) begin
                xs = floor_shr(x, i);
                ys = floor_shr(y, i);
                if (z >= 0) begin
                    x -= ys; y += xs; z -= atan_q16(i);
                end else begin
                    x += ys; y -= xs; z += atan_q16(i);
                end
            end
            if (y != 0) begin
                num = d2 * (use_tan ? x : (64'sd1 << 30));
                r = num / (2 * y);
                if (r > 65535) begin r = 65535; clip = 1; end
                if (r < -65535) begin r = -65535; clip = 1; end
            end
        end
        if (!(r < 74 && r > -74)) begin
            m = r < 0 ? -r : r;
            nearf = ((m - 74) << FFB) / m;
            farf = ((m + 74) << FFB) / m;
            if (r > 0) begin rf = nearf; lf = farf; end
            else begin rf = farf; lf = nearf; end
        end
        res.right_f = FACTOR_W'(clamp_factor(rf));
        res.left_f = FACTOR_W'(clamp_factor(lf));
        res.radius = r[RADIUS_W-1:0];
        res.clipped = clip;
        return res;
    endfunction

    // accept flag latched at the rising edge for the driver
    bit s_ready_seen = 1'b0;

    // driver: angles from the pending queue, random gaps, random m_ready
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready_seen) begin
                if (angle_q.size() > 0 && !sender_hold
                        && (quiet_phase || $urandom_range(99) >= 14)) begin
                    s_servo_angle <= angle_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= !stall_burst && (quiet_phase || $urandom_range(99) >= 14);
        end
    end

    always @(posedge aclk) begin
        s_ready_seen <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            expected_q.push_back(predict_wheel_factors(s_servo_angle));
    end

    // monitor
    always @(posedge aclk) begin
        wheel_res_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_right_factor, m_left_factor, m_turn_radius, m_radius_clipped};
            if (expected_q.size() == 0) begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result beat: %p", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: exp rf=%0d lf=%0d r=%0d c=%0d",
                                 want.right_f, want.left_f, $signed(want.radius),
                                 want.clipped, " got rf=%0d lf=%0d r=%0d c=%0d",
                                 got.right_f, got.left_f, $signed(got.radius),
                                 got.clipped);
                end
            end
        end
    end

    task automatic drain_all();
        while (angle_q.size() > 0 || s_valid || expected_q.size() > 0)
            @(posedge aclk);
    endtask

    task automatic write_geo(logic [1:0] idx, logic [3:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_STEERING_MODEL: geo_model = val[1:0];
            REG_STEERING_HOLE:  geo_steer_hole = val;
            REG_AXIS_HOLE:      geo_axis_hole = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [ANGLE_W-1:0] rand_angle();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return ANGLE_W'($urandom);
        if (pick < 3) return ANGLE_W'($signed($urandom_range(2048)) - 1024);
        return ANGLE_W'($signed($urandom_range(23040)) - 11520);
    endfunction

    task automatic directed_angles();
        logic signed [ANGLE_W-1:0] dir[$] = '{0, 1, -1, 1023, 1024, -1024, -1023,
            11520, -11520, 16383, -16384, 5000, -5000, 2000, -2000, 1100, -1100,
            15'sh2AAA, 15'sh5555, 23040 >> 1};
        foreach (dir[i]) angle_q.push_back(dir[i]);
    endtask

    initial begin
        logic [1:0] models[4] = '{MODEL_COMBINED, MODEL_ARTICULATED, MODEL_TURNTABLE, 2'd3};
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // reset geometry first
        directed_angles();
        drain_all();
        repeat (LATENCY + 5) @(posedge aclk);
        for (int ph = 0; ph < 8; ph++) begin
            write_geo(REG_STEERING_MODEL, {2'b00, models[ph % 4]});
            write_geo(REG_STEERING_HOLE, ph == 1 ? 4'd15 : (ph == 2 ? 4'd0 : 4'($urandom)));
            write_geo(REG_AXIS_HOLE, ph == 1 ? 4'd0 : (ph == 2 ? 4'd15 : 4'($urandom)));
            // hole 8/axis 0 gives zero articulated distance
            if (ph == 5) begin
                write_geo(REG_STEERING_HOLE, 4'd8);
                write_geo(REG_AXIS_HOLE, 4'd0);
            end
            quiet_phase = (ph == 3);
            if (ph < 2) directed_angles();
            for (int i = 0; i < 34; i++) angle_q.push_back(rand_angle());
            if (ph == 4) begin
                // long receiver stall while the sender keeps offering
                for (int i = 0; i < 60; i++) angle_q.push_back(rand_angle());
                fork
                    begin
                        stall_burst = 1'b1;
                        repeat (300) @(posedge aclk);
                        stall_burst = 1'b0;
                    end
                join_none
            end
            if (ph == 6) begin
                drain_all();
                sender_hold = 1'b1;
                for (int i = 0; i < 20; i++) angle_q.push_back(rand_angle());
                sender_hold = 1'b0;
            end
            drain_all();
            repeat (LATENCY + 5) @(posedge aclk);
        end
        quiet_phase = 1'b0;
        drain_all();
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end
endmodule
